### sv/toec_pkg.sv
package toec_pkg;

    // Item field widths
    localparam int CMD_W  = 8;
    localparam int TIME_W = 16;
    localparam int PIN_W  = 6;
    localparam int FLAG_W = 4;
    localparam int REQ_W  = 4;

    // Status byte bits
    localparam int STATUS_FULL = 6;
    localparam int STATUS_HOLD = 7;

    // Command byte bits
    localparam int CMD_SOFT_IRQ = 3;
    localparam int CMD_IRQ      = 4;
    localparam int CMD_LEVEL    = 5;
    localparam int CMD_TIMER2   = 6;

    // Request vector bits
    localparam int REQ_OUT_IRQ  = 0;
    localparam int REQ_SOFT_IRQ = 1;
    localparam int REQ_T2_RESET = 2;
    localparam int REQ_ADC      = 3;

    // Action codes (command low nibble)
    localparam logic [3:0] ACT_PIN_FIRST  = 4'h0;
    localparam logic [3:0] ACT_PIN_LAST   = 4'h5;
    localparam logic [3:0] ACT_PAIR01     = 4'h6;
    localparam logic [3:0] ACT_PAIR23     = 4'h7;
    localparam logic [3:0] ACT_SOFT_FIRST = 4'h8;
    localparam logic [3:0] ACT_SOFT_LAST  = 4'hb;
    localparam logic [3:0] ACT_T2_RESET   = 4'he;
    localparam logic [3:0] ACT_ADC        = 4'hf;

    localparam logic [PIN_W-1:0] PIN_MASK_01 = 6'h03;
    localparam logic [PIN_W-1:0] PIN_MASK_23 = 6'h0c;

    typedef enum logic [1:0] {
        OP_COMMIT = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_SCAN,
        S_DRAIN,
        S_REFILL,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic rd_en;
        logic refill;
        logic load_out;
    } t_dp_cmd;

endpackage

### sv/toec_ctrl.sv
module toec_ctrl
    import toec_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  t_op              i_op,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_rd_idx
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_free;
    logic             w_last;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last     = (r_idx == IDX_W'(SLOT_COUNT - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_COMMIT: n_state = S_COMMIT;
                        OP_TICK:   n_state = S_SCAN;
                        default:   n_state = S_RESULT;
                    endcase
                end
            end
            S_COMMIT: n_state = S_RESULT;
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_REFILL;
            S_REFILL: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands and handshake
    always_comb begin
        o_s_tready     = (r_state == S_IDLE);
        o_cmd          = '0;
        o_cmd.capture  = i_s_tvalid && o_s_tready;
        o_cmd.commit   = (r_state == S_COMMIT);
        o_cmd.rd_en    = (r_state == S_SCAN);
        o_cmd.refill   = (r_state == S_REFILL);
        o_cmd.load_out = (r_state == S_RESULT) && w_out_free;
        o_rd_idx       = r_idx;
        o_m_tvalid     = r_out_valid;
    end

    // Scan counter and result valid
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_SCAN) begin
            n_idx = w_last ? '0 : r_idx + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_scan_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) ##1 (r_state == S_SCAN) |-> (r_idx == '0))
        else $error("scan did not start at slot zero");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken one");

    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item not processed");
`endif

endmodule

### sv/toec_dp.sv
module toec_dp
    import toec_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [IDX_W-1:0]  i_rd_idx,
    input  t_op               i_op,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [TIME_W-1:0] i_fire_time,
    input  logic [TIME_W-1:0] i_timer1,
    input  logic [TIME_W-1:0] i_timer2,
    output logic [PIN_W-1:0]  o_pin_levels,
    output logic [7:0]        o_status_byte,
    output logic [FLAG_W-1:0] o_soft_flags,
    output logic [REQ_W-1:0]  o_req
);

    localparam int SLOT_W = CMD_W + TIME_W;

    // Lowest clear bit of the valid vector
    function automatic logic [IDX_W-1:0] first_free(input logic [SLOT_COUNT-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!v[k]) begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

    // Captured item
    t_op               r_op;
    logic [CMD_W-1:0]  r_cmd;
    logic [TIME_W-1:0] r_etime, r_t1, r_t2;

    // Store state
    logic [SLOT_W-1:0]     r_mem [SLOT_COUNT];
    logic [SLOT_W-1:0]     r_rd_data;
    logic                  r_eval_en;
    logic [IDX_W-1:0]      r_eval_idx;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [CMD_W-1:0]      r_hold_cmd;
    logic [TIME_W-1:0]     r_hold_time;
    logic [7:0]            r_io, n_io;
    logic [FLAG_W-1:0]     r_soft, n_soft;
    logic [REQ_W-1:0]      r_req, n_req;
    logic                  n_hold_load;

    // Memory write port
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [SLOT_W-1:0]     w_wdata;

    // Evaluation of the slot read last cycle
    logic [CMD_W-1:0]      w_ev_cmd;
    logic [TIME_W-1:0]     w_ev_time, w_now;
    logic                  w_fire;
    logic [3:0]            w_act;
    logic [PIN_W-1:0]      w_pin_mask;
    logic [IDX_W-1:0]      w_free;
    logic                  w_any_free;

    assign w_ev_cmd   = r_rd_data[SLOT_W-1:TIME_W];
    assign w_ev_time  = r_rd_data[TIME_W-1:0];
    assign w_now      = w_ev_cmd[CMD_TIMER2] ? r_t2 : r_t1;
    assign w_fire     = r_eval_en && r_valid[r_eval_idx] && (w_ev_time == w_now);
    assign w_act      = w_ev_cmd[3:0];
    assign w_free     = first_free(r_valid);
    assign w_any_free = !(&r_valid);

    // Pin mask of the action
    always_comb begin
        case (w_act) inside
            [ACT_PIN_FIRST:ACT_PIN_LAST]: w_pin_mask = PIN_W'(1) << w_act[2:0];
            ACT_PAIR01:                   w_pin_mask = PIN_MASK_01;
            ACT_PAIR23:                   w_pin_mask = PIN_MASK_23;
            default:                      w_pin_mask = '0;
        endcase
    end

    // Next store state: commit, fire, refill
    always_comb begin
        n_valid     = r_valid;
        n_io        = r_io;
        n_soft      = r_soft;
        n_req       = r_req;
        n_hold_load = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_free;
        w_wdata     = {r_cmd, r_etime};

        if (i_cmd.capture) begin
            n_req = '0;
        end

        if (i_cmd.commit) begin
            if (w_any_free) begin
                w_we             = 1'b1;
                n_valid[w_free]  = 1'b1;
                if (&n_valid) begin
                    n_io[STATUS_FULL] = 1'b1;
                end
            end else begin
                n_io[STATUS_FULL] = 1'b1;
                n_io[STATUS_HOLD] = 1'b1;
                n_hold_load       = 1'b1;
            end
        end

        if (w_fire) begin
            if ((&r_valid) && !r_io[STATUS_HOLD]) begin
                n_io[STATUS_FULL] = 1'b0;
            end
            n_valid[r_eval_idx] = 1'b0;
            if (w_ev_cmd[CMD_LEVEL]) begin
                n_io[PIN_W-1:0] = r_io[PIN_W-1:0] | w_pin_mask;
            end else begin
                n_io[PIN_W-1:0] = r_io[PIN_W-1:0] & ~w_pin_mask;
            end
            case (w_act) inside
                [ACT_SOFT_FIRST:ACT_SOFT_LAST]: n_soft = r_soft | (FLAG_W'(1) << w_ev_cmd[1:0]);
                ACT_T2_RESET:                   n_req[REQ_T2_RESET] = 1'b1;
                ACT_ADC:                        n_req[REQ_ADC] = 1'b1;
                default:                        ;
            endcase
            if (w_ev_cmd[CMD_IRQ]) begin
                if (w_ev_cmd[CMD_SOFT_IRQ]) begin
                    n_req[REQ_SOFT_IRQ] = 1'b1;
                end else begin
                    n_req[REQ_OUT_IRQ] = 1'b1;
                end
            end
        end

        if (i_cmd.refill && r_io[STATUS_HOLD] && w_any_free) begin
            w_we              = 1'b1;
            w_wdata           = {r_hold_cmd, r_hold_time};
            n_valid[w_free]   = 1'b1;
            n_io[STATUS_HOLD] = 1'b0;
            if (&n_valid) begin
                n_io[STATUS_FULL] = 1'b1;
            end
        end

        // A read clears the soft flags as its result is loaded into the result register
        if (i_cmd.load_out && (r_op == OP_READ)) begin
            n_soft = '0;
        end
    end

    // Slot memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_cmd   <= i_command;
            r_etime <= i_fire_time;
            r_t1    <= i_timer1;
            r_t2    <= i_timer2;
        end
        r_eval_idx <= i_rd_idx;
        if (i_cmd.load_out) begin
            o_pin_levels  <= r_io[PIN_W-1:0];
            o_status_byte <= r_io;
            o_soft_flags  <= r_soft;
            o_req         <= r_req;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_en   <= 1'b0;
            r_valid     <= '0;
            r_hold_cmd  <= '0;
            r_hold_time <= '0;
            r_io        <= '0;
            r_soft      <= '0;
            r_req       <= '0;
        end else begin
            r_eval_en <= i_cmd.rd_en;
            r_valid   <= n_valid;
            r_io      <= n_io;
            r_soft    <= n_soft;
            r_req     <= n_req;
            if (n_hold_load) begin
                r_hold_cmd  <= r_cmd;
                r_hold_time <= r_etime;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && r_io[STATUS_HOLD]) |-> (&r_valid))
        else $error("hold entry parked while a slot is free");

    a_commit_takes_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_any_free) |=>
        ($countones(r_valid) == $countones($past(r_valid)) + 1))
        else $error("commit did not occupy exactly one slot");

    a_fire_only_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval_en |=> ((r_valid & ~$past(r_valid)) == '0))
        else $error("scan set a valid bit");
`endif

endmodule

### sv/timed_output_event_cam_unit.sv
// Timed output event store. Each input item is a commit, a timer tick or a
// flag read (operation in tuser) and gives exactly one result item. A commit
// passes through the commit state before its result, a read or unused code goes
// straight to the result state, and a tick walks the slot memory one entry per
// cycle through its single read port, then refills a free slot from the hold
// register. Matching slots fire in slot order. A new item is taken as soon as
// the previous one has reached the result register, even if that result has
// not yet been taken.
module timed_output_event_cam_unit
    import toec_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // command[7:0], fire_time[23:8],
                                    // timer1_value[39:24], timer2_value[55:40]
    input  logic [1:0]  i_s_tuser,  // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // pin_levels[5:0], status_byte[13:6],
                                    // soft_timer_flags[17:14],
                                    // output_interrupt[18], software_interrupt[19],
                                    // timer2_reset_request[20],
                                    // adc_start_request[21], zero[23:22]
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    t_dp_cmd           w_cmd;
    logic [IDX_W-1:0]  w_rd_idx;
    t_op               w_op;
    logic [PIN_W-1:0]  w_pins;
    logic [7:0]        w_status;
    logic [FLAG_W-1:0] w_flags;
    logic [REQ_W-1:0]  w_req;

    assign w_op = t_op'(i_s_tuser);

    toec_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (w_op),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .o_rd_idx   (w_rd_idx)
    );

    toec_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_rd_idx      (w_rd_idx),
        .i_op          (w_op),
        .i_command     (i_s_tdata[7:0]),
        .i_fire_time   (i_s_tdata[23:8]),
        .i_timer1      (i_s_tdata[39:24]),
        .i_timer2      (i_s_tdata[55:40]),
        .o_pin_levels  (w_pins),
        .o_status_byte (w_status),
        .o_soft_flags  (w_flags),
        .o_req         (w_req)
    );

    // Result packing
    assign o_m_tdata = {2'b00, w_req[REQ_ADC], w_req[REQ_T2_RESET],
                        w_req[REQ_SOFT_IRQ], w_req[REQ_OUT_IRQ],
                        w_flags, w_status, w_pins};

endmodule
